// ===== sv/evbd_pkg.sv =====
// Shared types and constants of the energy variance beat detector.
package evbd_pkg;

   typedef struct packed {
      logic [31:0] frame_energy;
      logic [14:0] frame_level;
      logic [9:0]  frame_interval_ms;
   } req_type;

   typedef struct packed {
      logic        beat;
      logic        silent;
      logic [31:0] history_mean;
      logic [63:0] history_variance;
      logic [15:0] beats_seen;
   } rsp_type;

   typedef logic [0:0] csr_index_type;

   localparam csr_index_type CSR_THRESHOLD_GAIN = 1'b0;
   localparam csr_index_type CSR_HOLDOFF_MS     = 1'b1;

   localparam logic [15:0] GAIN_RESET    = 16'd250;
   localparam logic [15:0] HOLDOFF_RESET = 16'd300;
   localparam logic [14:0] QUIET_LIMIT   = 15'd128;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN,
      ST_MEAN_DIV,
      ST_PUSH,
      ST_VAR,
      ST_VAR_DIV,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_CMP,
      ST_DONE
   } state_type;

endpackage

// ===== sv/evbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module evbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/evbd_div.sv =====
// Restoring divider, one quotient bit per cycle.
module evbd_div #(
   parameter int DIVIDEND_W = 69,
   parameter int DIVISOR_W  = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;

   logic [DIVISOR_W:0] trial;
   logic [DIVISOR_W:0] trial_sub;
   logic               fits;

   always_comb begin
      trial     = {rem_ff, quot_ff[DIVIDEND_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = (trial >= {1'b0, den_ff});

      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;

      if (start) begin
         cnt_in  = CNT_W'(DIVIDEND_W);
         quot_in = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
         quot_in = {quot_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign busy     = (cnt_ff != '0);
   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== sv/energy_variance_beat_detector.sv =====
// Top level of the energy variance beat detector: sequencer, ring and arithmetic.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  evbd_pkg::req_type (one frame)
//   rsp      out        rsp_valid/rsp_ready  evbd_pkg::rsp_type (one result)
//   csr      in         csr_wr_en            csr_index, csr_wdata (16 bits)
//
// Per frame: a ring pass for the mean, the mean divide, the push, a ring pass for the
//   variance, the variance divide, the gain multiply and the compare; an empty ring skips
//   the mean divide. Both passes share the one RAM read port and the bit-serial divider
//   (ACC_W = 64 + clog2(HISTORY_DEPTH+1)); req_ready rises only back in idle.
// Reset: synchronous; ring contents are never cleared, only fill and head.
// Stalls: the next beat is taken while a result waits; only the final step needs rsp_ready.
module energy_variance_beat_detector #(
   parameter int HISTORY_DEPTH = 20,
   parameter int QUIET_FRAMES  = 60
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  evbd_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output evbd_pkg::rsp_type       rsp_data,
   input  logic                    csr_wr_en,
   input  evbd_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_wdata
);

   localparam int ADDR_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   // sum of up to HISTORY_DEPTH squared 32-bit differences
   localparam int ACC_W  = 64 + CNT_W;

   // control state
   evbd_pkg::state_type state_ff, state_in;
   logic [7:0]        quiet_ff, quiet_in;
   logic [15:0]       since_ff, since_in;
   logic [15:0]       beats_ff, beats_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [15:0]       gain_ff, gain_in;
   logic [15:0]       holdoff_ff, holdoff_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              rv_ff, rv_in;     // RAM read data valid
   logic              dv_ff, dv_in;     // difference valid
   logic              pv_ff, pv_in;     // square valid
   logic              rsp_valid_ff, rsp_valid_in;

   // datapath
   evbd_pkg::req_type item_ff, item_in;
   evbd_pkg::rsp_type rsp_ff, rsp_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [31:0]       diff_ff, diff_in;
   logic [63:0]       prod_ff, prod_in;
   logic [31:0]       mean_ff, mean_in;
   logic [63:0]       var_ff, var_in;
   logic [47:0]       plo_ff, plo_in;
   logic              over_ff, over_in;

   // shared multiplier operands
   logic [31:0] mul_a, mul_b;

   // RAM and divider hookup
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [31:0]       ram_rd_data;
   logic              div_start;
   logic              div_busy;
   logic              div_done;
   logic [ACC_W-1:0]  div_q;

   logic              pass_done;
   logic              silent;
   logic [16:0]       timer_sum;
   logic [15:0]       timer_sat;
   logic              beat;
   logic [79:0]       gain_var;
   logic [79:0]       scaled;

   evbd_ram #(
      .WIDTH (32),
      .DEPTH (HISTORY_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (head_ff),
      .wr_data (item_ff.frame_energy),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   evbd_div #(
      .DIVIDEND_W (ACC_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (fill_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   // all reads of a pass issued and drained through the pipeline
   assign pass_done = (idx_ff == fill_ff) && !rv_ff && !dv_ff && !pv_ff;
   assign silent    = (quiet_ff >= 8'(QUIET_FRAMES));
   assign timer_sum = {1'b0, since_ff} + 17'(item_ff.frame_interval_ms);
   assign timer_sat = timer_sum[16] ? 16'hFFFF : timer_sum[15:0];
   assign beat      = over_ff && !silent && (timer_sat >= holdoff_ff);
   // gain * variance assembled from the two 16x32 partial products
   assign gain_var  = {prod_ff[47:0], 32'b0} + {32'b0, plo_ff};
   assign scaled    = {32'b0, item_ff.frame_energy, 16'b0};

   always_comb begin
      state_in     = state_ff;
      quiet_in     = quiet_ff;
      since_in     = since_ff;
      beats_in     = beats_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      gain_in      = gain_ff;
      holdoff_in   = holdoff_ff;
      idx_in       = idx_ff;
      rv_in        = 1'b0;
      dv_in        = 1'b0;
      pv_in        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      acc_in       = acc_ff;
      diff_in      = diff_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      plo_in       = plo_ff;
      over_in      = over_ff;
      mul_a        = diff_ff;
      mul_b        = diff_ff;
      req_ready    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      div_start    = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            evbd_pkg::CSR_THRESHOLD_GAIN: gain_in    = csr_wdata;
            evbd_pkg::CSR_HOLDOFF_MS:     holdoff_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         evbd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in = req_data;
               // level under half a dB rounds to zero
               if (req_data.frame_level < evbd_pkg::QUIET_LIMIT) begin
                  if (quiet_ff != 8'hFF) begin
                     quiet_in = quiet_ff + 8'd1;
                  end
               end else begin
                  quiet_in = '0;
               end
               idx_in   = '0;
               acc_in   = '0;
               mean_in  = '0;
               state_in = evbd_pkg::ST_MEAN;
            end
         end
         evbd_pkg::ST_MEAN: begin
            if (idx_ff < fill_ff) begin
               ram_rd_en = 1'b1;
               idx_in    = idx_ff + CNT_W'(1);
               rv_in     = 1'b1;
            end
            if (rv_ff) begin
               acc_in = acc_ff + ACC_W'(ram_rd_data);
            end
            if (pass_done) begin
               if (fill_ff == '0) begin
                  state_in = evbd_pkg::ST_PUSH;
               end else begin
                  div_start = 1'b1;
                  state_in  = evbd_pkg::ST_MEAN_DIV;
               end
            end
         end
         evbd_pkg::ST_MEAN_DIV: begin
            if (div_done) begin
               mean_in  = div_q[31:0];
               state_in = evbd_pkg::ST_PUSH;
            end
         end
         evbd_pkg::ST_PUSH: begin
            ram_wr_en = 1'b1;
            head_in   = (head_ff == ADDR_W'(HISTORY_DEPTH - 1)) ? '0
                                                                : head_ff + ADDR_W'(1);
            if (fill_ff != CNT_W'(HISTORY_DEPTH)) begin
               fill_in = fill_ff + CNT_W'(1);
            end
            idx_in   = '0;
            acc_in   = '0;
            state_in = evbd_pkg::ST_VAR;
         end
         evbd_pkg::ST_VAR: begin
            // read -> |e - mean| -> square -> accumulate
            if (idx_ff < fill_ff) begin
               ram_rd_en = 1'b1;
               idx_in    = idx_ff + CNT_W'(1);
               rv_in     = 1'b1;
            end
            if (rv_ff) begin
               diff_in = (ram_rd_data >= mean_ff) ? ram_rd_data - mean_ff
                                                  : mean_ff - ram_rd_data;
               dv_in   = 1'b1;
            end
            pv_in = dv_ff;
            if (pv_ff) begin
               acc_in = acc_ff + ACC_W'(prod_ff);
            end
            if (pass_done) begin
               div_start = 1'b1;
               state_in  = evbd_pkg::ST_VAR_DIV;
            end
         end
         evbd_pkg::ST_VAR_DIV: begin
            if (div_done) begin
               var_in   = div_q[63:0];
               state_in = evbd_pkg::ST_MUL_LO;
            end
         end
         evbd_pkg::ST_MUL_LO: begin
            mul_a    = {16'b0, gain_ff};
            mul_b    = var_ff[31:0];
            state_in = evbd_pkg::ST_MUL_HI;
         end
         evbd_pkg::ST_MUL_HI: begin
            mul_a    = {16'b0, gain_ff};
            mul_b    = var_ff[63:32];
            plo_in   = prod_ff[47:0];
            state_in = evbd_pkg::ST_CMP;
         end
         evbd_pkg::ST_CMP: begin
            // energy * 2^16 > gain * variance, exact
            over_in  = (scaled > gain_var);
            state_in = evbd_pkg::ST_DONE;
         end
         evbd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.beat             = beat;
               rsp_in.silent           = silent;
               rsp_in.history_mean     = mean_ff;
               rsp_in.history_variance = var_ff;
               rsp_in.beats_seen       = beat ? beats_ff + 16'd1 : beats_ff;
               beats_in                = beat ? beats_ff + 16'd1 : beats_ff;
               since_in                = beat ? '0 : timer_sat;
               rsp_valid_in            = 1'b1;
               state_in                = evbd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = evbd_pkg::ST_IDLE;
         end
      endcase

      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= evbd_pkg::ST_IDLE;
         quiet_ff     <= '0;
         since_ff     <= '0;
         beats_ff     <= '0;
         fill_ff      <= '0;
         head_ff      <= '0;
         gain_ff      <= evbd_pkg::GAIN_RESET;
         holdoff_ff   <= evbd_pkg::HOLDOFF_RESET;
         idx_ff       <= '0;
         rv_ff        <= 1'b0;
         dv_ff        <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         quiet_ff     <= quiet_in;
         since_ff     <= since_in;
         beats_ff     <= beats_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         gain_ff      <= gain_in;
         holdoff_ff   <= holdoff_in;
         idx_ff       <= idx_in;
         rv_ff        <= rv_in;
         dv_ff        <= dv_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      acc_ff  <= acc_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      mean_ff <= mean_in;
      var_ff  <= var_in;
      plo_ff  <= plo_in;
      over_ff <= over_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // fill never passes the ring depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(HISTORY_DEPTH))
      else $error("ring fill beyond depth");

   // fill grows by at most one per frame
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (fill_ff == $past(fill_ff)) || (fill_ff == $past(fill_ff) + CNT_W'(1)))
      else $error("ring fill jumped");

   // divider is never restarted mid-run
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // a new result only comes out of the final step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == evbd_pkg::ST_DONE))
      else $error("result raised outside final step");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the energy variance beat detector.
module testbench;

   // Block configuration under test and the quiet-run threshold.
   localparam int RING_DEPTH = 20;
   localparam int QUIET_RUN  = 60;

   // Clock, reset and the block's ports. Every input starts at a known value.
   logic                    clock;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   evbd_pkg::req_type       req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   evbd_pkg::rsp_type       rsp_data;
   logic                    csr_wr_en = 1'b0;
   evbd_pkg::csr_index_type csr_index = evbd_pkg::CSR_THRESHOLD_GAIN;
   logic [15:0]             csr_wdata = '0;

   energy_variance_beat_detector #(
      .HISTORY_DEPTH(RING_DEPTH),
      .QUIET_FRAMES (QUIET_RUN)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop for a hang: the ~760 frames, even with worst-case sender gaps and
   // receiver stalls, finish well before it.
   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------
   // Detector model: our own copy of the ring, counters and registers.
   // ------------------------------------------------------------------
   logic [31:0] ring_energy [RING_DEPTH];
   int unsigned ring_count    = 0;
   int unsigned ring_pos      = 0;
   logic [7:0]  quiet_count   = '0;
   logic [15:0] ms_since_beat = '0;
   logic [15:0] beat_count    = '0;
   logic [15:0] gain_cfg      = evbd_pkg::GAIN_RESET;
   logic [15:0] holdoff_cfg   = evbd_pkg::HOLDOFF_RESET;

   // Results still owed by the block, oldest first.
   evbd_pkg::rsp_type pending_results[$];

   // Run statistics and failure count.
   int error_count     = 0;
   int frames_sent     = 0;
   int results_checked = 0;
   int beats_observed  = 0;
   int silent_observed = 0;
   int settings_used   = 0;

   // Turns off random idling on both sides for a stretch of traffic.
   bit steady_flow = 1'b0;

   // Advances the model by one frame and returns the result it should give.
   function automatic evbd_pkg::rsp_type detect_beat(evbd_pkg::req_type f);
      logic [63:0] total;
      logic [31:0] mean;
      logic [31:0] dev;
      logic [71:0] sq_sum;
      logic [63:0] spread;
      logic [16:0] ms;
      logic [95:0] lhs;
      logic [95:0] rhs;
      logic        quiet_now;
      logic        hit;
      evbd_pkg::rsp_type r;

      // quiet run counts this frame, saturating at 255
      if (f.frame_level < evbd_pkg::QUIET_LIMIT) begin
         if (quiet_count != 8'hFF) quiet_count = quiet_count + 8'd1;
      end else begin
         quiet_count = '0;
      end
      quiet_now = (quiet_count >= QUIET_RUN);

      // mean over the history before this frame goes in
      total = '0;
      for (int i = 0; i < ring_count; i++) total = total + 64'(ring_energy[i]);
      mean = (ring_count == 0) ? 32'd0 : 32'(total / ring_count);

      ring_energy[ring_pos] = f.frame_energy;
      ring_pos = (ring_pos + 1) % RING_DEPTH;
      if (ring_count < RING_DEPTH) ring_count++;

      // variance after the push, around the earlier mean; exact floor
      sq_sum = '0;
      for (int i = 0; i < ring_count; i++) begin
         dev = (ring_energy[i] >= mean) ? ring_energy[i] - mean : mean - ring_energy[i];
         sq_sum = sq_sum + 72'(dev) * 72'(dev);
      end
      spread = 64'(sq_sum / ring_count);

      ms = 17'(ms_since_beat) + 17'(f.frame_interval_ms);
      if (ms > 17'h0FFFF) ms = 17'h0FFFF;

      // energy * 2^16 > gain * variance, done wide enough to be exact
      lhs = {48'd0, f.frame_energy, 16'd0};
      rhs = 96'(gain_cfg) * 96'(spread);
      hit = (lhs > rhs) && !quiet_now && (ms >= 17'(holdoff_cfg));
      if (hit) begin
         beat_count = beat_count + 16'd1;
         ms = '0;
      end
      ms_since_beat = ms[15:0];

      r.beat             = hit;
      r.silent           = quiet_now;
      r.history_mean     = mean;
      r.history_variance = spread;
      r.beats_seen       = beat_count;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Result side: random backpressure plus the scoreboard compare.
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got 0x%0h expected 0x%0h (result %0d)",
               what, got, want, results_checked);
      error_count++;
   endtask

   task automatic check_result(input evbd_pkg::rsp_type got);
      evbd_pkg::rsp_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("result with nothing outstanding", 64'(got.history_mean), 64'd0);
      end else begin
         want = pending_results.pop_front();
         if (got.beat !== want.beat)
            report_mismatch("beat", 64'(got.beat), 64'(want.beat));
         if (got.silent !== want.silent)
            report_mismatch("silent", 64'(got.silent), 64'(want.silent));
         if (got.history_mean !== want.history_mean)
            report_mismatch("history_mean", 64'(got.history_mean), 64'(want.history_mean));
         if (got.history_variance !== want.history_variance)
            report_mismatch("history_variance", got.history_variance,
                            want.history_variance);
         if (got.beats_seen !== want.beats_seen)
            report_mismatch("beats_seen", 64'(got.beats_seen), 64'(want.beats_seen));
      end
      results_checked++;
      if (got.beat === 1'b1) beats_observed++;
      if (got.silent === 1'b1) silent_observed++;
   endtask

   // Handshake sampled with pre-edge values; ready for the next edge set here.
   // Mostly single idle cycles; now and then a stall long enough to overlap the
   // whole of the next frame's processing.
   int stall_left = 0;
   int stall_roll = 0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_result(rsp_data);
      stall_roll = $urandom_range(0, 9999);
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!steady_flow && stall_roll == 0) begin
         stall_left = $urandom_range(200, 400);
         rsp_ready <= 1'b0;
      end else if (!steady_flow && stall_roll < 1000) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Input side helpers.
   // ------------------------------------------------------------------
   function automatic evbd_pkg::req_type make_frame(input logic [31:0] energy,
                                                    input logic [14:0] level,
                                                    input logic [9:0] interval);
      evbd_pkg::req_type f;
      f.frame_energy      = energy;
      f.frame_level       = level;
      f.frame_interval_ms = interval;
      return f;
   endfunction

   // Offers one frame; valid stays up afterwards so back-to-back frames never
   // drop it. Anything else that advances time lowers it first.
   task automatic send_frame(input evbd_pkg::req_type f);
      int gap;
      if (!steady_flow && $urandom_range(0, 99) < 13) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 500) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.insert(pending_results.size(), detect_beat(f));
      frames_sent++;
   endtask

   // Sender holds off until every outstanding result is back, then a few
   // spare cycles so the block is fully idle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes both registers back to back; only called while drained.
   task automatic set_config(input logic [15:0] gain, input logic [15:0] holdoff);
      csr_wr_en <= 1'b1;
      csr_index <= evbd_pkg::CSR_THRESHOLD_GAIN;
      csr_wdata <= gain;
      @(posedge clock);
      csr_index <= evbd_pkg::CSR_HOLDOFF_MS;
      csr_wdata <= holdoff;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      gain_cfg    = gain;
      holdoff_cfg = holdoff;
      settings_used++;
   endtask

   function automatic logic [14:0] loud_level();
      return 15'($urandom_range(evbd_pkg::QUIET_LIMIT, 23040));
   endfunction

   function automatic logic [14:0] quiet_level();
      return 15'($urandom_range(0, evbd_pkg::QUIET_LIMIT - 1));
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset register values, empty history, field extremes, quiet threshold edge.
   task automatic test_reset_defaults();
      send_frame(make_frame(32'd0, 15'd0, 10'd0));
      send_frame(make_frame(32'hFFFF_FFFF, 15'd23040, 10'd1023));
      send_frame(make_frame(32'd0, 15'd127, 10'd1023));
      send_frame(make_frame(32'hFFFF_FFFF, 15'd128, 10'd0));
      send_frame(make_frame(32'd1, 15'd23040, 10'd1));
      send_frame(make_frame(32'h5555_AAAA, 15'h2AAA, 10'h2AA));
      send_frame(make_frame(32'hAAAA_5555, 15'h1555, 10'h155));
      // run of identical energies behind the extremes still in the ring
      repeat (6) send_frame(make_frame(32'h0001_0000, loud_level(), 10'd100));
   endtask

   // Gain of zero (any nonzero energy is over) and the largest gain.
   task automatic test_gain_limits();
      wait_drained();
      set_config(16'd0, 16'd0);
      send_frame(make_frame(32'd0, loud_level(), 10'd0));
      send_frame(make_frame(32'd1, loud_level(), 10'd0));
      send_frame(make_frame(32'hFFFF_FFFF, loud_level(), 10'd0));
      send_frame(make_frame(32'd0, loud_level(), 10'd5));
      wait_drained();
      set_config(16'hFFFF, 16'd0);
      send_frame(make_frame(32'hFFFF_FFFF, loud_level(), 10'd20));
      repeat (3) send_frame(make_frame($urandom, loud_level(), 10'd20));
      repeat (3) send_frame(make_frame(32'h8000_0000, loud_level(), 10'd20));
   endtask

   // Largest hold-off: only reachable once the beat timer saturates.
   task automatic test_holdoff_limit();
      wait_drained();
      set_config(16'd0, 16'hFFFF);
      repeat (70) send_frame(make_frame($urandom | 32'd1, loud_level(), 10'd1023));
   endtask

   // Quiet run: silence after the threshold count, cleared by one loud frame,
   // and held through the counter's saturation. Runs with no idling at all.
   task automatic test_quiet_run();
      wait_drained();
      set_config(16'd0, 16'd0);
      steady_flow = 1'b1;
      repeat (QUIET_RUN + 2) send_frame(make_frame($urandom, quiet_level(), 10'd23));
      send_frame(make_frame($urandom, 15'd128, 10'd23));
      repeat (262) send_frame(make_frame($urandom | 32'd1, quiet_level(), 10'd23));
      send_frame(make_frame($urandom, loud_level(), 10'd23));
      steady_flow = 1'b0;
   endtask

   // Phases of random settings; frames mostly follow a steady level with
   // noise and occasional spikes, which is where beats actually show up.
   task automatic test_random_traffic(input int phases, input int per_phase);
      logic [15:0] gain;
      logic [15:0] holdoff;
      logic [31:0] base;
      logic [32:0] spiked;
      logic [31:0] energy;
      logic [14:0] level;
      logic [9:0]  interval;
      int          pick;
      for (int p = 0; p < phases; p++) begin
         wait_drained();
         case ($urandom_range(0, 5))
            0:       gain = 16'd0;
            1:       gain = 16'hFFFF;
            2:       gain = evbd_pkg::GAIN_RESET;
            3:       gain = 16'($urandom_range(1, 16));
            4:       gain = 16'($urandom_range(17, 2000));
            default: gain = 16'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0:       holdoff = 16'd0;
            1:       holdoff = 16'hFFFF;
            2:       holdoff = evbd_pkg::HOLDOFF_RESET;
            3:       holdoff = 16'($urandom_range(0, 400));
            default: holdoff = 16'($urandom);
         endcase
         set_config(gain, holdoff);
         base = $urandom >> $urandom_range(0, 20);
         for (int k = 0; k < per_phase; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               energy = base + 32'($urandom_range(0, base >> 6));
            end else if (pick < 80) begin
               spiked = 33'(base) + 33'(base >> $urandom_range(0, 4));
               energy = spiked[32] ? 32'hFFFF_FFFF : spiked[31:0];
            end else if (pick < 88) begin
               energy = 32'd0;
            end else begin
               energy = $urandom;
            end
            level = ($urandom_range(0, 9) == 0) ? quiet_level() : loud_level();
            interval = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(15, 50)) :
                                                    10'($urandom_range(0, 1023));
            send_frame(make_frame(energy, level, interval));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_gain_limits();
      test_holdoff_limit();
      test_quiet_run();
      test_random_traffic(8, 42);

      // drain, then give the block a frame's worth of cycles to show strays
      wait_drained();
      repeat (600) @(posedge clock);

      $display("Run covered %0d frames and %0d checked results under %0d register settings.",
               frames_sent, results_checked, settings_used);
      $display("Detector reported %0d beats and %0d silent frames.",
               beats_observed, silent_observed);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         if (pending_results.size() != 0)
            $display("%0d results never arrived", pending_results.size());
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/evbd_pkg.sv
sv/evbd_ram.sv
sv/evbd_div.sv
sv/energy_variance_beat_detector.sv
test/testbench.sv
